FILE: rtl/core/fptw_pkg.sv
// Shared types, constants and helpers for the four-level page table walker.
`default_nettype none
package fptw_pkg;

   localparam int unsigned VA_WIDTH    = 64;
   localparam int unsigned PA_WIDTH    = 52;
   localparam int unsigned LIMIT_WIDTH = 49;
   localparam int unsigned LEVEL_WIDTH = 2;
   localparam int unsigned REQ_TDATA_WIDTH = 200;
   localparam int unsigned RSP_TDATA_WIDTH = 56;

   localparam logic [63:0] FRAME_MASK  = 64'h000F_FFFF_FFFF_F000;
   localparam logic [63:0] PAGE_OFFSET = 64'h0000_0000_0000_0FFF;
   localparam logic [63:0] SPAN_1G     = 64'h0000_0000_3FFF_FFFF;
   localparam logic [63:0] SPAN_2M     = 64'h0000_0000_001F_FFFF;
   localparam logic [63:0] PAGE_BYTES  = 64'h0000_0000_0000_1000;
   localparam logic [48:0] USER_LIMIT_RESET = 49'h0_8000_0000_0000;

   // Entry bit positions
   localparam int unsigned BIT_PRESENT  = 0;
   localparam int unsigned BIT_WRITABLE = 1;
   localparam int unsigned BIT_HUGE     = 7;

   // Table levels
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_PT   = 2'd0;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_PD   = 2'd1;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_PDP  = 2'd2;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_PML4 = 2'd3;

   typedef enum logic [1:0] {
      OP_TRANSLATE = 2'd0,
      OP_VALIDATE  = 2'd1,
      OP_ENTRY     = 2'd2,
      OP_UNUSED    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_MEM_READ   = 2'd0,
      KIND_XLATE_DONE = 2'd1,
      KIND_RANGE_DONE = 2'd2,
      KIND_UNUSED     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_XLATE = 2'd1,
      MODE_RANGE = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_ROOT_BASE  = 1'b0,
      CSR_USER_LIMIT = 1'b1
   } csr_index_type;

   // Byte address of the entry for va at the given level, inside a 4 KB table
   function automatic logic [PA_WIDTH-1:0] entry_addr(input logic [63:0] table_base,
                                                     input logic [63:0] va,
                                                     input logic [LEVEL_WIDTH-1:0] level);
      logic [8:0]  idx;
      logic [63:0] base;
      case (level)
         LEVEL_PT:   idx = va[20:12];
         LEVEL_PD:   idx = va[29:21];
         LEVEL_PDP:  idx = va[38:30];
         LEVEL_PML4: idx = va[47:39];
         default:    idx = va[47:39];
      endcase
      base = table_base & FRAME_MASK;
      return {base[PA_WIDTH-1:12], idx, 3'b000};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/four_level_page_table_walker_core.sv
// Four-level x86-64 page table walker: request register, walk logic, result register.
// Usage:
//   req_* carries translate and range-validate requests and the table entries that
//   memory returns; rsp_* carries entry read requests and walk completions.
//   A translate or validate request answers with an entry read (or an immediate
//   range reject); each returned entry answers with the next read or a completion.
//   A new translate or validate request drops any walk in progress.
//   A request is registered on accept, then processed into the result register
//   when that register is free or being drained; its response is then held on rsp_*
//   until taken.
//   Throughput: one request per cycle unless stalled; a single pass of mask, index,
//   add and compare logic between the two registers reads and writes the walk state.
//   Entries arriving while idle and unused opcodes produce no response.
//   When a result waits and rsp_tready is low the result register holds, the request
//   register fills, and req_tready drops until the result is taken.
//   Reset (synchronous, active high) empties both registers, returns to idle, restores
//   the register defaults. The user must write csr_* only while idle (not enforced).
`default_nettype none
module four_level_page_table_walker_core (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request channel
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // address[63:0], range_size[127:64], write_check[128], entry_data[192:129], zero pad
   input  wire logic [fptw_pkg::REQ_TDATA_WIDTH-1:0]    req_tdata,
   // opcode[1:0]
   input  wire logic [1:0]                              req_tuser,
   // response channel
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // result_address[51:0], ok[52], zero pad
   output logic [fptw_pkg::RSP_TDATA_WIDTH-1:0]         rsp_tdata,
   // kind[1:0]
   output logic [1:0]                                   rsp_tuser,
   // register write port
   input  wire logic                                    csr_we,
   input  wire logic                                    csr_index,
   input  wire logic [fptw_pkg::PA_WIDTH-1:0]           csr_wdata
);
   import fptw_pkg::*;

   // registers
   logic [PA_WIDTH-1:0]    root_base_ff;
   logic [LIMIT_WIDTH-1:0] user_limit_ff;

   // request register
   logic             in_valid_ff;
   opcode_type       in_op_ff;
   logic [63:0]      in_addr_ff;
   logic [63:0]      in_size_ff;
   logic             in_write_check_ff;
   logic [63:0]      in_entry_ff;

   // walk state
   logic [LEVEL_WIDTH-1:0] level_ff, level_in;
   mode_type               mode_ff, mode_in;
   logic [63:0]            cur_page_ff, cur_page_in;
   logic [63:0]            last_page_ff, last_page_in;
   logic                   write_req_ff, write_req_in;

   // result register
   logic                   out_valid_ff;
   kind_type               out_kind_ff, out_kind_in;
   logic [PA_WIDTH-1:0]    out_addr_ff, out_addr_in;
   logic                   out_ok_ff, out_ok_in;
   logic                   emit_in;

   logic                   advance;
   logic [64:0]            range_end;
   logic [63:0]            end_minus_one;
   logic [63:0]            page_base;
   logic [63:0]            next_page;
   logic [63:0]            span_mask;
   logic [63:0]            leaf_pa;
   logic                   range_bad;
   logic                   leaf;
   logic [LEVEL_WIDTH-1:0] level_down;
   kind_type               fail_kind;

   // Advance when the result register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {{(RSP_TDATA_WIDTH-PA_WIDTH-1){1'b0}}, out_ok_ff, out_addr_ff};

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_base_ff  <= '0;
         user_limit_ff <= USER_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ROOT_BASE:  root_base_ff  <= csr_wdata;
            CSR_USER_LIMIT: user_limit_ff <= csr_wdata[LIMIT_WIDTH-1:0];
            default:        root_base_ff  <= root_base_ff;
         endcase
      end
   end

   // Capture a request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff          <= opcode_type'(req_tuser);
         in_addr_ff        <= req_tdata[63:0];
         in_size_ff        <= req_tdata[127:64];
         in_write_check_ff <= req_tdata[128];
         in_entry_ff       <= req_tdata[192:129];
      end
   end

   // Range arithmetic and leaf decode
   assign range_end     = {1'b0, in_addr_ff} + {1'b0, in_size_ff};
   assign end_minus_one = range_end[63:0] - 64'd1;
   assign range_bad     = (in_addr_ff == '0) || (in_size_ff == '0) || range_end[64] ||
                          (range_end[63:0] > {{(64-LIMIT_WIDTH){1'b0}}, user_limit_ff});
   assign page_base     = in_addr_ff & ~PAGE_OFFSET;
   assign next_page     = cur_page_ff + PAGE_BYTES;
   assign level_down    = level_ff - 2'd1;
   assign fail_kind     = (mode_ff == MODE_XLATE) ? KIND_XLATE_DONE : KIND_RANGE_DONE;

   always_comb begin
      leaf      = 1'b0;
      span_mask = PAGE_OFFSET;
      if (level_ff == LEVEL_PT) begin
         leaf = 1'b1;
      end else if (level_ff == LEVEL_PDP && in_entry_ff[BIT_HUGE]) begin
         leaf      = 1'b1;
         span_mask = SPAN_1G;
      end else if (level_ff == LEVEL_PD && in_entry_ff[BIT_HUGE]) begin
         leaf      = 1'b1;
         span_mask = SPAN_2M;
      end
   end

   assign leaf_pa = (in_entry_ff & FRAME_MASK & ~span_mask) | (cur_page_ff & span_mask);

   // Walk step: next state and result
   always_comb begin
      level_in     = level_ff;
      mode_in      = mode_ff;
      cur_page_in  = cur_page_ff;
      last_page_in = last_page_ff;
      write_req_in = write_req_ff;
      emit_in      = 1'b0;
      out_kind_in  = KIND_MEM_READ;
      out_addr_in  = '0;
      out_ok_in    = 1'b0;
      case (in_op_ff)
         OP_TRANSLATE: begin
            mode_in     = MODE_XLATE;
            cur_page_in = in_addr_ff;
            level_in    = LEVEL_PML4;
            emit_in     = 1'b1;
            out_addr_in = entry_addr({12'b0, root_base_ff}, in_addr_ff, LEVEL_PML4);
         end
         OP_VALIDATE: begin
            emit_in = 1'b1;
            if (range_bad) begin
               mode_in     = MODE_IDLE;
               level_in    = LEVEL_PT;
               out_kind_in = KIND_RANGE_DONE;
            end else begin
               mode_in      = MODE_RANGE;
               cur_page_in  = page_base;
               last_page_in = end_minus_one & ~PAGE_OFFSET;
               write_req_in = in_write_check_ff;
               level_in     = LEVEL_PML4;
               out_addr_in  = entry_addr({12'b0, root_base_ff}, page_base, LEVEL_PML4);
            end
         end
         OP_ENTRY: begin
            if (mode_ff != MODE_IDLE) begin
               emit_in = 1'b1;
               if (!in_entry_ff[BIT_PRESENT]) begin
                  mode_in     = MODE_IDLE;
                  level_in    = LEVEL_PT;
                  out_kind_in = fail_kind;
               end else if (!leaf) begin
                  level_in    = level_down;
                  out_addr_in = entry_addr(in_entry_ff, cur_page_ff, level_down);
               end else if (mode_ff == MODE_XLATE) begin
                  mode_in     = MODE_IDLE;
                  level_in    = LEVEL_PT;
                  out_kind_in = KIND_XLATE_DONE;
                  out_addr_in = leaf_pa[PA_WIDTH-1:0];
                  out_ok_in   = 1'b1;
               end else if (write_req_ff && !in_entry_ff[BIT_WRITABLE]) begin
                  mode_in     = MODE_IDLE;
                  level_in    = LEVEL_PT;
                  out_kind_in = fail_kind;
               end else if (cur_page_ff == last_page_ff) begin
                  mode_in     = MODE_IDLE;
                  level_in    = LEVEL_PT;
                  out_kind_in = KIND_RANGE_DONE;
                  out_ok_in   = 1'b1;
               end else begin
                  // advance to the next page and walk again from the root
                  cur_page_in = next_page;
                  level_in    = LEVEL_PML4;
                  out_addr_in = entry_addr({12'b0, root_base_ff}, next_page, LEVEL_PML4);
               end
            end
         end
         default: begin
            emit_in = 1'b0;
         end
      endcase
   end

   // Walk state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= LEVEL_PT;
         mode_ff      <= MODE_IDLE;
         cur_page_ff  <= '0;
         last_page_ff <= '0;
         write_req_ff <= 1'b0;
      end else if (advance) begin
         level_ff     <= level_in;
         mode_ff      <= mode_in;
         cur_page_ff  <= cur_page_in;
         last_page_ff <= last_page_in;
         write_req_ff <= write_req_in;
      end
   end

   // Result register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit_in;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit_in) begin
         out_kind_ff <= out_kind_in;
         out_addr_ff <= out_addr_in;
         out_ok_ff   <= out_ok_in;
      end
   end

endmodule
`default_nettype wire
